// File: rtl/core/shift_rotate_flag_unit_defines.svh
// ----------------------------------------------------------------------------
// shift_rotate_flag_unit_defines.svh
// Assertion macros for the shift/rotate flag unit. Each expects clk and rst_n
// in scope.
// ----------------------------------------------------------------------------
`ifndef SHIFT_ROTATE_FLAG_UNIT_DEFINES_SVH
`define SHIFT_ROTATE_FLAG_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SRFU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shift_rotate_flag_unit: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define SRFU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shift_rotate_flag_unit: next-cycle check failed");

`endif

// File: rtl/core/srfu_pkg.sv
// ----------------------------------------------------------------------------
// srfu_pkg
// Opcodes, widths and pipeline stage types of the shift/rotate flag unit.
// ----------------------------------------------------------------------------
`default_nettype none

package srfu_pkg;

  localparam int OP_W   = 3;
  localparam int DATA_W = 16;
  localparam int CNT_W  = 8;
  localparam int AMT_W  = 5;

  // Group-2 operation codes
  localparam logic [OP_W-1:0] OP_ROL = 3'd0;
  localparam logic [OP_W-1:0] OP_ROR = 3'd1;
  localparam logic [OP_W-1:0] OP_RCL = 3'd2;
  localparam logic [OP_W-1:0] OP_RCR = 3'd3;
  localparam logic [OP_W-1:0] OP_SHL = 3'd4;
  localparam logic [OP_W-1:0] OP_SHR = 3'd5;
  localparam logic [OP_W-1:0] OP_SAR = 3'd6;
  // Unused selector: passes the operand and flags through
  localparam logic [OP_W-1:0] OP_NONE = 3'd7;

  // Operand widths as shift amounts
  localparam logic [AMT_W-1:0] BYTE_BITS = 5'd8;
  localparam logic [AMT_W-1:0] WORD_BITS = 5'd16;

  // Incoming flags
  typedef struct packed {
    logic cf;
    logic of;
    logic sf;
    logic zf;
    logic pf;
  } flags_t;

  // Stage 1: decoded operation and shift amount
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic              wide;
    logic              by_count;
    logic              nop;
    logic [DATA_W-1:0] val;
    logic [AMT_W-1:0]  amt;
    flags_t            flg;
  } s1_t;

  // Stage 2: shifted value and carry
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic              wide;
    logic              by_count;
    logic              nop;
    logic              old_msb;
    logic [DATA_W-1:0] res;
    logic              cf;
    flags_t            flg;
  } s2_t;

endpackage

`default_nettype wire

// File: rtl/core/shift_rotate_flag_unit.sv
// ----------------------------------------------------------------------------
// shift_rotate_flag_unit
// 8086 group-2 shift and rotate unit (ROL, ROR, RCL, RCR, SHL, SHR, SAR) on a
// byte or 16-bit word, with CF, OF, SF, ZF and PF.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  op, size, count mode, operand,
//                                          count, five flags
//   out_     output     out_valid/out_stall result, five flags
//
// One word per cycle sustained while out_stall is low; words pass through the amount
// decode, barrel shifter and flag register stages.
// Reset clears the three stage valid bits only.
// A stalled output holds its word; empty stages keep filling, and in_stall
// rises only when all three stages are full and out_stall is high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "shift_rotate_flag_unit_defines.svh"

module shift_rotate_flag_unit (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  [srfu_pkg::OP_W-1:0]         in_req_type,
  input  wire                               in_wide,
  input  wire                               in_by_count,
  input  wire  [srfu_pkg::DATA_W-1:0]       in_operand,
  input  wire  [srfu_pkg::CNT_W-1:0]        in_shift_count,
  input  wire                               in_carry_in,
  input  wire                               in_overflow_in,
  input  wire                               in_sign_in,
  input  wire                               in_zero_in,
  input  wire                               in_parity_in,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [srfu_pkg::DATA_W-1:0]       out_result,
  output logic                              out_carry_out,
  output logic                              out_overflow_out,
  output logic                              out_sign_out,
  output logic                              out_zero_out,
  output logic                              out_parity_out
);

  import srfu_pkg::*;

  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  logic s1_vld_r, s2_vld_r, out_vld_r;
  logic en1, en2, en3;

  logic [DATA_W-1:0] res_r, res_nxt;
  logic              cf_r, cf_nxt, of_r, of_nxt, sf_r, sf_nxt;
  logic              zf_r, zf_nxt, pf_r, pf_nxt;
  logic              wide_r;

  // Advance a stage when it is empty or the stage after it moves
  assign en3      = !out_vld_r || !out_stall;
  assign en2      = !s2_vld_r || en3;
  assign en1      = !s1_vld_r || en2;
  assign in_stall = !en1;

  // Stage 1: effective count, rotate modulus and shift amount
  always_comb begin
    logic [CNT_W-1:0] n;
    logic [5:0]       m17;
    logic [4:0]       m9;
    logic [AMT_W-1:0] wl;
    logic [AMT_W-1:0] kmod;
    logic [AMT_W-1:0] cmod;
    n = in_by_count ? in_shift_count : 8'd1;
    wl = in_wide ? WORD_BITS : BYTE_BITS;
    // n mod 17: 16 is -1 mod 17
    if (n[3:0] >= n[7:4]) begin
      m17 = {2'b00, n[3:0]} - {2'b00, n[7:4]};
    end else begin
      m17 = {2'b00, n[3:0]} + 6'd17 - {2'b00, n[7:4]};
    end
    // n mod 9: 64 is 1 and 8 is -1 mod 9
    m9 = {3'b000, n[7:6]} + {2'b00, n[2:0]} + 5'd9 - {2'b00, n[5:3]};
    if (m9 >= 5'd18) begin
      m9 = m9 - 5'd18;
    end else if (m9 >= 5'd9) begin
      m9 = m9 - 5'd9;
    end
    kmod = in_wide ? {1'b0, n[3:0]} : {2'b00, n[2:0]};
    cmod = in_wide ? m17[AMT_W-1:0] : m9;

    s1_nxt.op       = in_req_type;
    s1_nxt.wide     = in_wide;
    s1_nxt.by_count = in_by_count;
    s1_nxt.nop      = (in_req_type == OP_NONE) || (n == '0);
    s1_nxt.val      = in_wide ? in_operand : {8'h00, in_operand[7:0]};
    s1_nxt.flg      = '{cf: in_carry_in, of: in_overflow_in, sf: in_sign_in,
                        zf: in_zero_in, pf: in_parity_in};
    // Rotates become a right shift of a doubled word
    case (in_req_type)
      OP_ROL:  s1_nxt.amt = wl - kmod;
      OP_ROR:  s1_nxt.amt = kmod;
      OP_RCL:  s1_nxt.amt = wl + 5'd1 - cmod;
      OP_RCR:  s1_nxt.amt = cmod;
      OP_SHL, OP_SHR: begin
        if (n > {3'b000, wl + 5'd1}) begin
          s1_nxt.amt = wl + 5'd1;
        end else begin
          s1_nxt.amt = n[AMT_W-1:0];
        end
      end
      OP_SAR: begin
        if (n > {3'b000, wl}) begin
          s1_nxt.amt = wl;
        end else begin
          s1_nxt.amt = n[AMT_W-1:0];
        end
      end
      default: s1_nxt.amt = '0;
    endcase
  end

  // Stage 2: barrel shift and carry out
  always_comb begin
    logic [DATA_W-1:0]   v;
    logic                c;
    logic [2*DATA_W+1:0] dbl;
    logic [2*DATA_W+1:0] rot;
    logic [2*DATA_W-1:0] sl;
    logic [DATA_W:0]     sr;
    logic [DATA_W:0]     sext;
    logic [DATA_W+1:0]   sa;
    logic [DATA_W-1:0]   rres;
    v = s1_r.val;
    c = s1_r.flg.cf;
    // Build the doubled word for the rotate width (8, 9, 16 or 17 bits)
    if (s1_r.op == OP_RCL || s1_r.op == OP_RCR) begin
      if (s1_r.wide) begin
        dbl = {c, v, c, v};
      end else begin
        dbl = {16'h0000, c, v[7:0], c, v[7:0]};
      end
    end else begin
      if (s1_r.wide) begin
        dbl = {2'b00, v, v};
      end else begin
        dbl = {18'h00000, v[7:0], v[7:0]};
      end
    end
    rot  = dbl >> s1_r.amt;
    sl   = {16'h0000, v} << s1_r.amt;
    sr   = {v, 1'b0} >> s1_r.amt;
    sext = s1_r.wide ? {v[15], v} : {{9{v[7]}}, v[7:0]};
    sa   = $unsigned($signed({sext, 1'b0}) >>> s1_r.amt);
    rres = s1_r.wide ? rot[15:0] : {8'h00, rot[7:0]};

    s2_nxt.op       = s1_r.op;
    s2_nxt.wide     = s1_r.wide;
    s2_nxt.by_count = s1_r.by_count;
    s2_nxt.nop      = s1_r.nop;
    s2_nxt.old_msb  = s1_r.wide ? v[15] : v[7];
    s2_nxt.flg      = s1_r.flg;
    case (s1_r.op)
      OP_ROL: begin
        s2_nxt.res = rres;
        s2_nxt.cf  = rres[0];
      end
      OP_ROR: begin
        s2_nxt.res = rres;
        s2_nxt.cf  = s1_r.wide ? rot[15] : rot[7];
      end
      OP_RCL, OP_RCR: begin
        s2_nxt.res = rres;
        s2_nxt.cf  = s1_r.wide ? rot[16] : rot[8];
      end
      OP_SHL: begin
        s2_nxt.res = s1_r.wide ? sl[15:0] : {8'h00, sl[7:0]};
        s2_nxt.cf  = s1_r.wide ? sl[16] : sl[8];
      end
      OP_SHR: begin
        s2_nxt.res = sr[DATA_W:1];
        s2_nxt.cf  = sr[0];
      end
      OP_SAR: begin
        s2_nxt.res = s1_r.wide ? sa[DATA_W:1] : {8'h00, sa[8:1]};
        s2_nxt.cf  = sa[0];
      end
      default: begin
        s2_nxt.res = v;
        s2_nxt.cf  = c;
      end
    endcase
    // Zero count or unused code: pass value and carry through
    if (s1_r.nop) begin
      s2_nxt.res = v;
      s2_nxt.cf  = c;
    end
  end

  // Stage 3: result flags
  always_comb begin
    logic new_msb;
    logic keep;
    new_msb = s2_r.wide ? s2_r.res[15] : s2_r.res[7];
    keep    = s2_r.nop || !s2_r.op[2];
    res_nxt = s2_r.res;
    cf_nxt  = s2_r.cf;
    of_nxt  = (s2_r.nop || s2_r.by_count) ? s2_r.flg.of : (s2_r.old_msb ^ new_msb);
    sf_nxt  = keep ? s2_r.flg.sf : new_msb;
    zf_nxt  = keep ? s2_r.flg.zf : (s2_r.res == '0);
    pf_nxt  = keep ? s2_r.flg.pf : ~^s2_r.res[7:0];
  end

  // Hold valid bits under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (en1) begin
        s1_vld_r <= in_valid;
      end
      if (en2) begin
        s2_vld_r <= s1_vld_r;
      end
      if (en3) begin
        out_vld_r <= s2_vld_r;
      end
    end
  end

  // Advance payload registers
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_r <= s1_nxt;
    end
    if (en2) begin
      s2_r <= s2_nxt;
    end
    if (en3) begin
      res_r  <= res_nxt;
      cf_r   <= cf_nxt;
      of_r   <= of_nxt;
      sf_r   <= sf_nxt;
      zf_r   <= zf_nxt;
      pf_r   <= pf_nxt;
      wide_r <= s2_r.wide;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_result       = res_r;
  assign out_carry_out    = cf_r;
  assign out_overflow_out = of_r;
  assign out_sign_out     = sf_r;
  assign out_zero_out     = zf_r;
  assign out_parity_out   = pf_r;

  // Input stalls only when the whole pipe is full behind a stalled output
  `SRFU_ASSERT_IMPL(a_stall_full, in_stall, out_valid && out_stall && s1_vld_r && s2_vld_r)
  // Accepted word lands in stage 1
  `SRFU_ASSERT_NEXT(a_accept_lands, in_valid && !in_stall, s1_vld_r)
  // Byte results keep the upper byte clear
  `SRFU_ASSERT_IMPL(a_byte_upper, out_valid && !wide_r, out_result[15:8] == 8'h00)

endmodule

`default_nettype wire
